// File: rtl/core/itsi_pkg.sv
// Shared constants, command/status types and helpers for the IMU time-sync interpolator.
package itsi_pkg;

    localparam int DEPTH      = 16;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int NCH        = 8;
    localparam int CH_IDX_W   = $clog2(NCH);
    localparam int CH_W       = 32;
    localparam int ROW_W      = NCH * CH_W;
    localparam int STAMP_W    = 48;
    localparam int DATA_W     = STAMP_W + ROW_W;
    localparam int GAP_W      = 20;
    localparam int FRAC_BITS  = 16;
    localparam int SCALE_BITS = 28;
    localparam int Q_W        = SCALE_BITS + 2;
    localparam int DIV_STEPS  = SCALE_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int WRAP_STEPS = 16;
    localparam int WRAP_K_W   = $clog2(WRAP_STEPS);
    localparam int MOD_W      = 35;

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(200000);

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_FULL = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [MOD_W-1:0] PI_FIX = PI_FULL[MOD_W-1:0];
    localparam logic [MOD_W-1:0] TWO_PI = {PI_FIX[MOD_W-2:0], 1'b0};

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_SYNC = 1'b1;

    typedef struct packed {
        logic                push;
        logic                capture;
        logic                pop;
        logic                div_init;
        logic                div_step;
        logic                mul;
        logic                acc;
        logic [CH_IDX_W-1:0] ch;
        logic                wrap_init;
        logic                wrap_step;
        logic [WRAP_K_W-1:0] k;
        logic                emit_ok;
        logic                emit_fail;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fill_ge2;
        logic t0_gt;
        logic t1_lt;
        logic gap;
        logic out_free;
    } dp_stat_t;

    function automatic logic [CH_W-1:0] sat32(input logic signed [MOD_W+1:0] v);
        logic signed [MOD_W+1:0] hi;
        logic signed [MOD_W+1:0] lo;
        hi = (MOD_W+2)'(signed'(33'sh0_7FFF_FFFF));
        lo = -(MOD_W+2)'(signed'(33'sh0_8000_0000));
        if (v > hi) return 32'h7FFF_FFFF;
        if (v < lo) return 32'h8000_0000;
        return v[CH_W-1:0];
    endfunction

endpackage

// File: rtl/core/itsi_ctrl.sv
// Sequencer for push, discard, divide, interpolate and heading-wrap steps.
module itsi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    input  itsi_pkg::dp_stat_t   stat,
    output itsi_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_DIVS  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_WRAPI = 4'd7;
    localparam logic [3:0] S_WRAPS = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_FAIL  = 4'd10;

    logic [3:0]                    state_reg, state_next;
    logic [itsi_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [itsi_pkg::CH_IDX_W-1:0] ch_reg, ch_next;
    logic                          gap_done_reg, gap_done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ch_reg       <= '0;
            gap_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ch_reg       <= ch_next;
            gap_done_reg <= gap_done_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        gap_done_next = gap_done_reg;
        cmd           = '0;
        cmd.ch        = ch_reg;
        cmd.k         = cnt_reg[itsi_pkg::WRAP_K_W-1:0];
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == itsi_pkg::CMD_SYNC) begin
                        cmd.capture   = 1'b1;
                        gap_done_next = 1'b0;
                        state_next    = S_LOAD;
                    end else begin
                        cmd.push = 1'b1;
                    end
                end
            end
            S_LOAD: state_next = S_CHECK;
            S_CHECK: begin
                if (!stat.fill_ge2) begin
                    state_next = S_FAIL;
                end else if (gap_done_reg) begin
                    state_next = S_DIVI;
                end else if (stat.t0_gt) begin
                    state_next = S_FAIL;
                end else if (stat.t1_lt) begin
                    cmd.pop    = 1'b1;
                    state_next = S_LOAD;
                end else if (stat.gap) begin
                    cmd.pop       = 1'b1;
                    gap_done_next = 1'b1;
                    state_next    = S_LOAD;
                end else begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVS;
            end
            S_DIVS: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == itsi_pkg::DIV_CNT_W'(itsi_pkg::DIV_STEPS - 1)) begin
                    ch_next    = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (ch_reg == itsi_pkg::CH_IDX_W'(itsi_pkg::NCH - 1)) begin
                    state_next = S_WRAPI;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_WRAPI: begin
                cmd.wrap_init = 1'b1;
                cnt_next      = itsi_pkg::DIV_CNT_W'(itsi_pkg::WRAP_STEPS - 1);
                state_next    = S_WRAPS;
            end
            S_WRAPS: begin
                cmd.wrap_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit_ok = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FAIL: begin
                if (stat.out_free) begin
                    cmd.emit_fail = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/itsi_dp.sv
// Sample FIFO memories, discard tests, scale divider, lerp multiplier and heading wrap.
module itsi_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [itsi_pkg::DATA_W-1:0]   s_tdata,
    input  logic                          cfg_we,
    input  logic [itsi_pkg::GAP_W-1:0]    cfg_wdata,
    input  itsi_pkg::ctrl_cmd_t           cmd,
    output itsi_pkg::dp_stat_t            stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [itsi_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tuser
);

    localparam int SW = itsi_pkg::STAMP_W;
    localparam int CW = itsi_pkg::CH_W;
    localparam int QW = itsi_pkg::Q_W;
    localparam int MW = itsi_pkg::MOD_W;
    localparam int PW = CW + 1 + QW;

    logic [SW-1:0]              stamp_mem [itsi_pkg::DEPTH];
    logic [itsi_pkg::ROW_W-1:0] row_mem   [itsi_pkg::DEPTH];

    logic [itsi_pkg::PTR_W-1:0] read_slot_reg, read_slot_next, slot1;
    logic [itsi_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [itsi_pkg::CNT_W:0]   wr_sum;
    logic [itsi_pkg::PTR_W-1:0] wr_slot;
    logic [itsi_pkg::GAP_W-1:0] gap_reg;
    logic [CW-1:0]              last_heading_reg, last_pitch_reg;
    logic                       m_tvalid_reg, m_tuser_reg;
    logic [itsi_pkg::DATA_W-1:0] m_tdata_reg;

    logic [SW-1:0]              t_reg, t0_reg, t1_reg;
    logic [itsi_pkg::ROW_W-1:0] row0_reg, row1_reg;

    logic [SW-1:0]  b_reg, r_reg;
    logic [QW-1:0]  q_reg;
    logic           neg_reg, fix_reg;

    logic [PW-1:0]  prod_reg;
    logic [CW-1:0]  f0_reg;
    logic           mneg_reg;
    logic [CW-1:0]  v_reg [itsi_pkg::NCH];

    logic [MW-1:0]  mod_reg;
    logic signed [MW-1:0] dh_reg;
    logic           wpos_reg, wneg_reg;

    logic signed [SW:0]   num, den;
    logic [SW-1:0]        a_mag, b_mag;
    logic [SW:0]          r2;
    logic signed [CW:0]   diff;
    logic [CW:0]          dmag;
    logic [63:0]          rsum;
    logic signed [MW+1:0] lsum, tmag;
    logic signed [MW-1:0] dh, pi_s, hd;
    logic [MW-1:0]        wsub;
    logic signed [MW+1:0] pdiff;

    assign slot1   = (read_slot_reg == itsi_pkg::PTR_W'(itsi_pkg::DEPTH - 1)) ?
                     '0 : read_slot_reg + 1'b1;
    assign wr_sum  = {1'b0, fill_reg} + (itsi_pkg::CNT_W+1)'(read_slot_reg);
    assign wr_slot = (wr_sum >= (itsi_pkg::CNT_W+1)'(itsi_pkg::DEPTH)) ?
                     itsi_pkg::PTR_W'(wr_sum - (itsi_pkg::CNT_W+1)'(itsi_pkg::DEPTH)) :
                     itsi_pkg::PTR_W'(wr_sum);

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stamp_mem[wr_slot] <= s_tdata[SW-1:0];
            row_mem[wr_slot]   <= s_tdata[itsi_pkg::DATA_W-1:SW];
        end
        t0_reg   <= stamp_mem[read_slot_reg];
        t1_reg   <= stamp_mem[slot1];
        row0_reg <= row_mem[read_slot_reg];
        row1_reg <= row_mem[slot1];
    end

    always_comb begin
        read_slot_next = read_slot_reg;
        fill_next      = fill_reg;
        if (cmd.push) begin
            if (fill_reg == itsi_pkg::CNT_W'(itsi_pkg::DEPTH)) read_slot_next = slot1;
            else fill_next = fill_reg + 1'b1;
        end else if (cmd.pop) begin
            read_slot_next = slot1;
            fill_next      = fill_reg - 1'b1;
        end
    end

    assign stat.fill_ge2 = fill_reg >= itsi_pkg::CNT_W'(2);
    assign stat.t0_gt    = t0_reg > t_reg;
    assign stat.t1_lt    = t1_reg < t_reg;
    assign stat.gap      = ((t_reg - t0_reg) > SW'(gap_reg)) ||
                           ((t1_reg - t_reg) > SW'(gap_reg));
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign num   = $signed({1'b0, t_reg}) - $signed({1'b0, t0_reg});
    assign den   = $signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg});
    assign a_mag = num[SW] ? SW'(-num) : num[SW-1:0];
    assign b_mag = den[SW] ? SW'(-den) : den[SW-1:0];
    assign r2    = {r_reg, 1'b0};

    assign diff  = (CW+1)'($signed(row1_reg[cmd.ch*CW +: CW])) -
                   (CW+1)'($signed(row0_reg[cmd.ch*CW +: CW]));
    assign dmag  = diff[CW] ? (CW+1)'(-diff) : diff[CW:0];
    assign rsum  = 64'(prod_reg) + (64'd1 << (itsi_pkg::SCALE_BITS - 1));
    assign tmag  = $signed({2'b00, rsum[itsi_pkg::SCALE_BITS +: MW]});
    assign lsum  = (MW+2)'($signed(f0_reg)) + (mneg_reg ? -tmag : tmag);

    assign pi_s  = $signed(itsi_pkg::PI_FIX);
    assign dh    = MW'($signed(v_reg[6])) - MW'($signed(last_heading_reg));
    assign wsub  = itsi_pkg::TWO_PI << cmd.k;
    assign pdiff = (MW+2)'($signed(v_reg[7])) - (MW+2)'($signed(last_pitch_reg));

    always_comb begin
        if (wpos_reg) begin
            hd = (mod_reg == '0) ? pi_s :
                 pi_s + $signed(mod_reg) - $signed(itsi_pkg::TWO_PI);
        end else if (wneg_reg) begin
            hd = (mod_reg == '0) ? -pi_s :
                 -pi_s - $signed(mod_reg) + $signed(itsi_pkg::TWO_PI);
        end else begin
            hd = dh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) t_reg <= s_tdata[SW-1:0];
        if (cmd.div_init) begin
            b_reg   <= b_mag;
            neg_reg <= num[SW] ^ den[SW];
            if (a_mag == '0 || b_mag == '0) begin
                q_reg   <= '0;
                fix_reg <= 1'b1;
            end else if ({1'b0, a_mag} >= {b_mag, 1'b0}) begin
                q_reg   <= QW'(1) << (itsi_pkg::SCALE_BITS + 1);
                fix_reg <= 1'b1;
            end else begin
                fix_reg <= 1'b0;
                if (a_mag >= b_mag) begin
                    q_reg <= QW'(1);
                    r_reg <= a_mag - b_mag;
                end else begin
                    q_reg <= '0;
                    r_reg <= a_mag;
                end
            end
        end else if (cmd.div_step && !fix_reg) begin
            if (r2 >= {1'b0, b_reg}) begin
                r_reg <= SW'(r2 - {1'b0, b_reg});
                q_reg <= {q_reg[QW-2:0], 1'b1};
            end else begin
                r_reg <= r2[SW-1:0];
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.mul) begin
            prod_reg <= PW'(dmag) * PW'(q_reg);
            f0_reg   <= row0_reg[cmd.ch*CW +: CW];
            mneg_reg <= diff[CW] ^ neg_reg;
        end
        if (cmd.acc) v_reg[cmd.ch] <= itsi_pkg::sat32(lsum);
        if (cmd.wrap_init) begin
            dh_reg   <= dh;
            wpos_reg <= dh > pi_s;
            wneg_reg <= dh < -pi_s;
            mod_reg  <= (dh > pi_s) ? MW'(dh - pi_s) : MW'(-pi_s - dh);
        end else if (cmd.wrap_step) begin
            if (mod_reg >= wsub) mod_reg <= mod_reg - wsub;
        end
        if (cmd.emit_ok) begin
            m_tdata_reg <= {itsi_pkg::sat32(pdiff), hd[CW-1:0], v_reg[5], v_reg[4],
                            v_reg[3], v_reg[2], v_reg[1], v_reg[0], t_reg};
            m_tuser_reg <= 1'b1;
        end else if (cmd.emit_fail) begin
            m_tdata_reg <= {itsi_pkg::ROW_W'(0), t_reg};
            m_tuser_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_slot_reg    <= '0;
            fill_reg         <= '0;
            gap_reg          <= itsi_pkg::GAP_RESET;
            last_heading_reg <= '0;
            last_pitch_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            read_slot_reg <= read_slot_next;
            fill_reg      <= fill_next;
            if (cfg_we) gap_reg <= cfg_wdata;
            if (cmd.emit_ok) begin
                last_heading_reg <= v_reg[6];
                last_pitch_reg   <= v_reg[7];
            end
            if (cmd.emit_ok || cmd.emit_fail) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= itsi_pkg::CNT_W'(itsi_pkg::DEPTH)) else $error("fill count overflow");
    a_pop_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> fill_reg >= itsi_pkg::CNT_W'(2)) else $error("pop with too few samples");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_ok || cmd.emit_fail) |-> stat.out_free) else $error("result overwritten");
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_ok |=> m_tvalid && m_tuser) else $error("result word not shown");
`endif

endmodule

// File: rtl/core/imu_time_sync_interpolator.sv
// Top level of the IMU time-sync interpolator: sequencer plus datapath.
// A push word (tuser 0) is taken in the idle state and makes no result. A sync word (tuser 1)
// runs the discard tests on the registered FIFO read, popping each sample discarded, then the
// bit-serial scale divider, one pass per channel on the shared multiplier and the bit-serial
// heading wrap. No new word is taken during a sync, but pushes are taken while a result word
// waits on m_tready.
module imu_time_sync_interpolator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [itsi_pkg::GAP_W-1:0]   cfg_wdata,   // max_gap_us
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [itsi_pkg::DATA_W-1:0]  s_tdata,     // stamp_us, vel_north, vel_east, vel_up,
                                                      // rate_x, rate_y, rate_z, heading_rad, pitch_rad
    input  logic                         s_tuser,     // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [itsi_pkg::DATA_W-1:0]  m_tdata,     // out_stamp_us, out_vel_north, out_vel_east,
                                                      // out_vel_up, out_rate_x, out_rate_y,
                                                      // out_rate_z, heading_change, pitch_change
    output logic                         m_tuser      // ok
);

    itsi_pkg::ctrl_cmd_t cmd;
    itsi_pkg::dp_stat_t  stat;

    itsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itsi_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
